[sv/cmps_pkg.sv]
// Shared constants, register codes and the arctangent table of the compass heading block.
`timescale 1ns / 1ps

package cmps_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int ITER_W = $clog2(CORDIC_ITERATIONS);

	localparam int MAG_W    = 16;
	localparam int CORR_W   = 17;
	localparam int IN_SHIFT = 8;
	localparam int DP_W     = 28;
	localparam int ANG_FRAC = 12;
	localparam int HEAD_W   = 15;
	localparam int CNT_W    = 16;

	localparam int FULL_TURN = 23040;
	localparam int HALF_TURN = 11520;

	localparam logic signed [DP_W-1:0] Z_HALF    = DP_W'(HALF_TURN * (1 << ANG_FRAC));
	localparam logic signed [DP_W-1:0] ROUND_BIT = DP_W'(1 << (ANG_FRAC - 1));

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CAL_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 2'd2;

	localparam logic [CNT_W-1:0] CAL_SAMPLES_RST = 16'd500;

	localparam logic signed [MAG_W-1:0] MAG_MAX = 16'sh7FFF;
	localparam logic signed [MAG_W-1:0] MAG_MIN = 16'sh8000;

	// Arctangent of 2^-i in 1/64 degree with twelve fraction bits.
	function automatic logic signed [DP_W-1:0] atan_entry(input logic [4:0] idx);
		logic signed [DP_W-1:0] v;
		unique case (idx)
			5'd0:  v = DP_W'(11796480);
			5'd1:  v = DP_W'(6963869);
			5'd2:  v = DP_W'(3679517);
			5'd3:  v = DP_W'(1867780);
			5'd4:  v = DP_W'(937515);
			5'd5:  v = DP_W'(469214);
			5'd6:  v = DP_W'(234664);
			5'd7:  v = DP_W'(117339);
			5'd8:  v = DP_W'(58671);
			5'd9:  v = DP_W'(29335);
			5'd10: v = DP_W'(14668);
			5'd11: v = DP_W'(7334);
			5'd12: v = DP_W'(3667);
			5'd13: v = DP_W'(1833);
			5'd14: v = DP_W'(917);
			5'd15: v = DP_W'(458);
			5'd16: v = DP_W'(229);
			5'd17: v = DP_W'(115);
			5'd18: v = DP_W'(57);
			5'd19: v = DP_W'(29);
			5'd20: v = DP_W'(14);
			5'd21: v = DP_W'(7);
			5'd22: v = DP_W'(4);
			5'd23: v = DP_W'(2);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[sv/compass_heading_with_hard_iron_cal.sv]
// Compass heading with hard-iron calibration: min/max trackers and an iterative CORDIC.
// A measure beat runs through the states CALC, ITER (once per CORDIC iteration), ROUND and OUT
// before its result is loaded into the output register; a calibration beat runs through CALC and OUT.
// One CORDIC stage is reused per cycle for the iterations.
// The input stalls until the result sits in the output register, which may still be waiting
// while the next beat is taken.
// Reset clears the configuration registers to their defaults, the trackers to empty and the offsets to zero.
`timescale 1ns / 1ps

module compass_heading_with_hard_iron_cal
	import cmps_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [MAG_W-1:0]     mag_x,
	input  logic signed [MAG_W-1:0]     mag_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        is_heading,
	output logic [HEAD_W-1:0]           heading,
	output logic signed [HEAD_W-1:0]    heading_diff,
	output logic                        cal_done,
	output logic signed [MAG_W-1:0]     cal_offset_x,
	output logic signed [MAG_W-1:0]     cal_offset_y
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CALC  = 3'd1;
	localparam logic [2:0] ST_ITER  = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0] state_q;

	logic                     cal_mode_q;
	logic [CNT_W-1:0]         cal_samples_q;
	logic [HEAD_W-1:0]        target_q;

	logic signed [MAG_W-1:0]  x_lo_q, x_hi_q, y_lo_q, y_hi_q;
	logic [CNT_W-1:0]         cal_count_q;
	logic signed [MAG_W-1:0]  off_x_q, off_y_q;

	logic signed [MAG_W-1:0]  mx_q, my_q;
	logic signed [DP_W-1:0]   x_q, y_q, z_q;
	logic [ITER_W-1:0]        iter_q;
	logic                     zero_q;
	logic                     meas_q;
	logic                     done_q;
	logic [HEAD_W-1:0]        head_q;

	logic                     out_valid_q;
	logic                     is_heading_q;
	logic [HEAD_W-1:0]        heading_q;
	logic signed [HEAD_W-1:0] diff_q;
	logic                     cal_done_q;
	logic signed [MAG_W-1:0]  out_off_x_q, out_off_y_q;

	logic in_acc;
	logic out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Calibration tracker update.
	logic signed [MAG_W-1:0] nxl, nxh, nyl, nyh;
	logic [CNT_W-1:0]        cnt_n, limit;
	logic                    run_end;
	logic signed [MAG_W:0]   sum_x, sum_y, adj_x, adj_y;

	always_comb begin
		nxl     = (mx_q < x_lo_q) ? mx_q : x_lo_q;
		nxh     = (mx_q > x_hi_q) ? mx_q : x_hi_q;
		nyl     = (my_q < y_lo_q) ? my_q : y_lo_q;
		nyh     = (my_q > y_hi_q) ? my_q : y_hi_q;
		cnt_n   = cal_count_q + 1'b1;
		limit   = (cal_samples_q == '0) ? CNT_W'(1) : cal_samples_q;
		run_end = (cnt_n >= limit) || (cnt_n == '0);
		sum_x   = {nxh[MAG_W-1], nxh} + {nxl[MAG_W-1], nxl};
		sum_y   = {nyh[MAG_W-1], nyh} + {nyl[MAG_W-1], nyl};
		// Adding the sign bit before the shift makes the halving truncate toward zero.
		adj_x   = sum_x + {{MAG_W{1'b0}}, sum_x[MAG_W]};
		adj_y   = sum_y + {{MAG_W{1'b0}}, sum_y[MAG_W]};
	end

	// Offset correction and CORDIC start vector.
	logic signed [CORR_W-1:0] xc, yc;
	logic signed [DP_W-1:0]   x_init, y_init;

	always_comb begin
		xc     = {mx_q[MAG_W-1], mx_q} - {off_x_q[MAG_W-1], off_x_q};
		yc     = {my_q[MAG_W-1], my_q} - {off_y_q[MAG_W-1], off_y_q};
		x_init = {{(DP_W-CORR_W-IN_SHIFT){xc[CORR_W-1]}}, xc, {IN_SHIFT{1'b0}}};
		y_init = {{(DP_W-CORR_W-IN_SHIFT){yc[CORR_W-1]}}, yc, {IN_SHIFT{1'b0}}};
	end

	// The shared CORDIC stage.
	logic signed [DP_W-1:0] xs, ys, at;
	always_comb begin
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		at = atan_entry(5'(iter_q));
	end

	// Rounding and wrap of the final angle.
	logic signed [DP_W-1:0]         zr;
	logic signed [DP_W-ANG_FRAC-1:0] h_raw, h_wrap;
	always_comb begin
		zr    = z_q + ROUND_BIT;
		h_raw = zr[DP_W-1:ANG_FRAC];
		if (h_raw < 0) begin
			h_wrap = h_raw + (DP_W-ANG_FRAC)'(FULL_TURN);
		end else if (h_raw >= FULL_TURN) begin
			h_wrap = h_raw - (DP_W-ANG_FRAC)'(FULL_TURN);
		end else begin
			h_wrap = h_raw;
		end
	end

	// Difference to the target heading.
	logic [HEAD_W-1:0]   tgt_r;
	logic signed [15:0]  d_raw, d_wrap;
	always_comb begin
		tgt_r = (target_q >= FULL_TURN) ? target_q - HEAD_W'(FULL_TURN) : target_q;
		d_raw = $signed({1'b0, tgt_r}) - $signed({1'b0, head_q});
		if (d_raw > HALF_TURN) begin
			d_wrap = d_raw - 16'(FULL_TURN);
		end else if (d_raw < -HALF_TURN) begin
			d_wrap = d_raw + 16'(FULL_TURN);
		end else begin
			d_wrap = d_raw;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_mode_q    <= 1'b0;
			cal_samples_q <= CAL_SAMPLES_RST;
			target_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_MODE:    cal_mode_q    <= cfg_data[0];
				REG_CAL_SAMPLES: cal_samples_q <= cfg_data;
				REG_TARGET:      target_q      <= cfg_data[HEAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, trackers and offsets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_lo_q      <= MAG_MAX;
			x_hi_q      <= MAG_MIN;
			y_lo_q      <= MAG_MAX;
			y_hi_q      <= MAG_MIN;
			cal_count_q <= '0;
			off_x_q     <= '0;
			off_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (cal_mode_q) begin
						if (run_end) begin
							off_x_q     <= adj_x[MAG_W:1];
							off_y_q     <= adj_y[MAG_W:1];
							x_lo_q      <= MAG_MAX;
							x_hi_q      <= MAG_MIN;
							y_lo_q      <= MAG_MAX;
							y_hi_q      <= MAG_MIN;
							cal_count_q <= '0;
						end else begin
							x_lo_q      <= nxl;
							x_hi_q      <= nxh;
							y_lo_q      <= nyl;
							y_hi_q      <= nyh;
							cal_count_q <= cnt_n;
						end
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_ITER;
					end
				end
				ST_ITER: begin
					if (iter_q == ITER_W'(CORDIC_ITERATIONS - 1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mx_q <= mag_x;
			my_q <= mag_y;
		end
		unique case (state_q)
			ST_CALC: begin
				meas_q <= !cal_mode_q;
				done_q <= cal_mode_q && run_end;
				zero_q <= (xc == '0) && (yc == '0);
				iter_q <= '0;
				// In the left half plane the vector is turned by half a turn first.
				if (xc < 0) begin
					x_q <= -x_init;
					y_q <= -y_init;
					z_q <= Z_HALF;
				end else begin
					x_q <= x_init;
					y_q <= y_init;
					z_q <= '0;
				end
			end
			ST_ITER: begin
				iter_q <= iter_q + 1'b1;
				if (!y_q[DP_W-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end
			end
			ST_ROUND: begin
				head_q <= zero_q ? '0 : h_wrap[HEAD_W-1:0];
			end
			ST_OUT: begin
				if (out_free) begin
					is_heading_q <= meas_q;
					heading_q    <= meas_q ? head_q : '0;
					diff_q       <= meas_q ? d_wrap[HEAD_W-1:0] : '0;
					cal_done_q   <= done_q;
					out_off_x_q  <= off_x_q;
					out_off_y_q  <= off_y_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign is_heading   = is_heading_q;
	assign heading      = heading_q;
	assign heading_diff = diff_q;
	assign cal_done     = cal_done_q;
	assign cal_offset_x = out_off_x_q;
	assign cal_offset_y = out_off_y_q;

endmodule

[sv/cmps_checker.sv]
// Port-level checks for the compass heading block, bound to its top level.
`timescale 1ns / 1ps

module cmps_checker
	import cmps_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic                     is_heading,
	input logic [HEAD_W-1:0]        heading,
	input logic signed [HEAD_W-1:0] heading_diff,
	input logic                     cal_done
);

	// A waiting result beat keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(heading) && $stable(heading_diff)
			&& $stable(is_heading) && $stable(cal_done))
		else $error("stalled result beat changed");

	// The block is busy in the cycle after taking a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again straight after a beat");

	// Calibration beats carry no heading.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_heading |-> heading == '0 && heading_diff == '0)
		else $error("calibration beat with a heading");

	// Heading beats are in range and never end a calibration run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_heading |-> !cal_done && heading < HEAD_W'(FULL_TURN)
			&& heading_diff <= HALF_TURN && heading_diff >= -HALF_TURN)
		else $error("heading beat out of range");

endmodule

bind compass_heading_with_hard_iron_cal cmps_checker u_cmps_checker (.*);

[bench/tb_top.sv]
// Self-checking bench for the compass heading block: directed corners, random phases, scoreboard.
`timescale 1ns / 1ps

import cmps_pkg::*;

typedef struct packed {
	logic                     is_heading;
	logic [HEAD_W-1:0]        heading;
	logic signed [HEAD_W-1:0] heading_diff;
	logic                     cal_done;
	logic signed [MAG_W-1:0]  ofs_x;
	logic signed [MAG_W-1:0]  ofs_y;
} compass_result_t;

class compass_scoreboard;
	logic              cal_mode;
	logic [CFG_W-1:0]  samples_reg;
	logic [HEAD_W-1:0] target_reg;
	int                x_lo, x_hi, y_lo, y_hi;
	int                run_count;
	int                off_x, off_y;
	longint            atan_lut [24];
	compass_result_t   pending_results [$];
	int                mismatches;

	function new();
		atan_lut = '{11796480, 6963869, 3679517, 1867780, 937515, 469214, 234664, 117339,
			58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
			229, 115, 57, 29, 14, 7, 4, 2};
		cal_mode = 1'b0;
		samples_reg = 16'd500;
		target_reg = '0;
		restart_trackers();
		off_x = 0;
		off_y = 0;
		mismatches = 0;
	endfunction

	function void restart_trackers();
		x_lo = 32767;
		x_hi = -32768;
		y_lo = 32767;
		y_hi = -32768;
		run_count = 0;
	endfunction

	function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_CAL_MODE: begin
				cal_mode = data[0];
			end
			REG_CAL_SAMPLES: begin
				samples_reg = data;
			end
			REG_TARGET: begin
				target_reg = data[HEAD_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Vectoring rotation of the corrected vector down to the X axis; the angle gathered
	// on the way is the heading.
	function int heading_of(int xc, int yc);
		longint x, y, z, xs, ys, h;
		int i;
		if (xc == 0 && yc == 0)
			return 0;
		x = longint'(xc) <<< IN_SHIFT;
		y = longint'(yc) <<< IN_SHIFT;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = longint'(HALF_TURN) <<< ANG_FRAC;
		end
		for (i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_lut[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_lut[i];
			end
		end
		h = (z + (longint'(1) <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
		while (h < 0)
			h = h + FULL_TURN;
		while (h >= FULL_TURN)
			h = h - FULL_TURN;
		return int'(h);
	endfunction

	function void note_sample(logic signed [MAG_W-1:0] mx, logic signed [MAG_W-1:0] my);
		compass_result_t res;
		int vx, vy, limit, hd, tgt, diff;
		res = '0;
		vx = int'(mx);
		vy = int'(my);
		if (cal_mode) begin
			limit = (samples_reg == 0) ? 1 : int'(samples_reg);
			if (vx < x_lo) x_lo = vx;
			if (vx > x_hi) x_hi = vx;
			if (vy < y_lo) y_lo = vy;
			if (vy > y_hi) y_hi = vy;
			run_count = (run_count + 1) & 32'hFFFF;
			if (run_count >= limit || run_count == 0) begin
				off_x = (x_hi + x_lo) / 2;
				off_y = (y_hi + y_lo) / 2;
				restart_trackers();
				res.cal_done = 1'b1;
			end
		end else begin
			res.is_heading = 1'b1;
			hd = heading_of(vx - off_x, vy - off_y);
			tgt = int'(target_reg);
			if (tgt >= FULL_TURN)
				tgt = tgt - FULL_TURN;
			diff = tgt - hd;
			if (diff > HALF_TURN)
				diff = diff - FULL_TURN;
			else if (diff < -HALF_TURN)
				diff = diff + FULL_TURN;
			res.heading = hd[HEAD_W-1:0];
			res.heading_diff = diff[HEAD_W-1:0];
		end
		res.ofs_x = off_x[MAG_W-1:0];
		res.ofs_y = off_y[MAG_W-1:0];
		pending_results.push_back(res);
	endfunction

	function void check_result(compass_result_t got);
		compass_result_t want;
		logic bad;
		if (pending_results.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: result beat with nothing outstanding: %p", $realtime, got);
			mismatches++;
			return;
		end
		want = pending_results.pop_front();
		bad = (got.is_heading !== want.is_heading) || (got.heading !== want.heading) ||
			(got.heading_diff !== want.heading_diff) || (got.cal_done !== want.cal_done) ||
			(got.ofs_x !== want.ofs_x) || (got.ofs_y !== want.ofs_y);
		if (bad) begin
			if (mismatches < 10) begin
				$display("%0t: result mismatch", $realtime);
				$display("  expected is_heading=%0d heading=%0d diff=%0d done=%0d off=(%0d,%0d)",
					want.is_heading, want.heading, want.heading_diff, want.cal_done,
					want.ofs_x, want.ofs_y);
				$display("  actual   is_heading=%0d heading=%0d diff=%0d done=%0d off=(%0d,%0d)",
					got.is_heading, got.heading, got.heading_diff, got.cal_done,
					got.ofs_x, got.ofs_y);
			end
			mismatches++;
		end
	endfunction

	function int outstanding();
		return pending_results.size();
	endfunction
endclass

module tb_top;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_BEATS = 1400;
	localparam int HOLD_OFF_CYCLES = 300;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [MAG_W-1:0]  mag_x = '0;
	logic signed [MAG_W-1:0]  mag_y = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     is_heading;
	logic [HEAD_W-1:0]        heading;
	logic signed [HEAD_W-1:0] heading_diff;
	logic                     cal_done;
	logic signed [MAG_W-1:0]  cal_offset_x;
	logic signed [MAG_W-1:0]  cal_offset_y;

	compass_scoreboard sb = new();
	int  in_idle_pct = 9;
	int  out_idle_pct = 80;
	int  beats_sent = 0;
	bit  hold_off_req = 1'b0;

	compass_heading_with_hard_iron_cal DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mag_x        (mag_x),
		.mag_y        (mag_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_heading   (is_heading),
		.heading      (heading),
		.heading_diff (heading_diff),
		.cal_done     (cal_done),
		.cal_offset_x (cal_offset_x),
		.cal_offset_y (cal_offset_y)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic signed [MAG_W-1:0] rand_mag();
		return MAG_W'($urandom);
	endfunction

	function automatic logic signed [MAG_W-1:0] clamp_mag(int v);
		if (v > 32767)
			return MAG_MAX;
		if (v < -32768)
			return MAG_MIN;
		return v[MAG_W-1:0];
	endfunction

	function automatic int spread(int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	function automatic logic [CFG_W-1:0] rand_target();
		if ($urandom_range(7) == 0)
			return CFG_W'($urandom_range(FULL_TURN, 32767));
		return CFG_W'($urandom_range(0, FULL_TURN - 1));
	endfunction

	// Valid is only lowered when a gap follows, so a back-to-back beat never sees a
	// low and a high scheduled in the same step.
	task automatic send_sample(logic signed [MAG_W-1:0] x, logic signed [MAG_W-1:0] y);
		int gap;
		gap = 0;
		while ($urandom_range(99) < in_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mag_x <= x;
		mag_y <= y;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.note_sample(x, y);
		beats_sent++;
	endtask

	// Registers change only with the block empty.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	// The receiver holds off while beats keep coming, so the block fills and stalls its input.
	task automatic held_burst();
		hold_off_req = 1'b1;
		repeat (12) send_sample(rand_mag(), rand_mag());
	endtask

	task automatic directed_checks();
		send_sample(16'sd0, 16'sd0);
		send_sample(MAG_MAX, 16'sd0);
		send_sample(MAG_MIN, 16'sd0);
		send_sample(16'sd0, MAG_MAX);
		send_sample(16'sd0, MAG_MIN);
		send_sample(MAG_MIN, MAG_MIN);
		send_sample(MAG_MAX, MAG_MAX);
		send_sample(-16'sd1, 16'sd1);
		// Targets past a full turn wrap back by one turn.
		write_reg(REG_TARGET, 16'h7FFF);
		send_sample(16'sd100, -16'sd300);
		write_reg(REG_TARGET, CFG_W'(FULL_TURN - 1));
		send_sample(-16'sd200, 16'sd50);
		write_reg(REG_SPARE, 16'hFFFF);
		send_sample(16'sd3000, 16'sd3000);
		// A sample count of zero ends the run after one sample.
		write_reg(REG_CAL_MODE, 16'd1);
		write_reg(REG_CAL_SAMPLES, 16'd0);
		send_sample(MAG_MAX, MAG_MAX);
		write_reg(REG_CAL_MODE, 16'd0);
		send_sample(MAG_MIN, MAG_MIN);
		write_reg(REG_CAL_MODE, 16'd1);
		write_reg(REG_CAL_SAMPLES, 16'd1);
		send_sample(MAG_MIN, MAG_MIN);
		write_reg(REG_CAL_MODE, 16'd0);
		send_sample(MAG_MAX, MAG_MAX);
		// Lowering the limit below the running count ends the run on the next sample.
		write_reg(REG_CAL_MODE, 16'd1);
		write_reg(REG_CAL_SAMPLES, 16'd10);
		repeat (3) send_sample(rand_mag(), rand_mag());
		write_reg(REG_CAL_SAMPLES, 16'd2);
		send_sample(rand_mag(), rand_mag());
		// Leaving calibration mid-run keeps the trackers for when it resumes.
		write_reg(REG_CAL_SAMPLES, 16'd5);
		repeat (2) send_sample(rand_mag(), rand_mag());
		write_reg(REG_CAL_MODE, 16'd0);
		send_sample(rand_mag(), rand_mag());
		write_reg(REG_CAL_MODE, 16'd1);
		repeat (3) send_sample(rand_mag(), rand_mag());
	endtask

	task automatic run_phase();
		int kind, n, k, cx, cy, r;
		logic [CFG_W-1:0] lim;
		kind = $urandom_range(9);
		if (kind <= 5) begin
			// A full calibration run around a centre, then headings about that centre.
			cx = int'($urandom_range(0, 40000)) - 20000;
			cy = int'($urandom_range(0, 40000)) - 20000;
			r = $urandom_range(1, 14000);
			lim = ($urandom_range(15) == 0) ? '0 : CFG_W'($urandom_range(1, 24));
			n = (lim == 0) ? 1 : int'(lim);
			write_reg(REG_CAL_MODE, 16'd1);
			write_reg(REG_CAL_SAMPLES, lim);
			repeat (n) send_sample(clamp_mag(cx + spread(r)), clamp_mag(cy + spread(r)));
			write_reg(REG_CAL_MODE, 16'd0);
			write_reg(REG_TARGET, rand_target());
			repeat ($urandom_range(6, 30)) begin
				if ($urandom_range(9) == 0)
					send_sample(rand_mag(), rand_mag());
				else
					send_sample(clamp_mag(cx + spread(r)), clamp_mag(cy + spread(r)));
			end
		end else if (kind <= 7) begin
			write_reg(REG_CAL_MODE, 16'd0);
			write_reg(REG_TARGET, rand_target());
			repeat ($urandom_range(5, 30)) send_sample(rand_mag(), rand_mag());
		end else begin
			// Broken runs: cut short by a lower limit or interrupted by measuring.
			n = $urandom_range(3, 40);
			k = $urandom_range(1, n - 1);
			write_reg(REG_CAL_MODE, 16'd1);
			write_reg(REG_CAL_SAMPLES, CFG_W'(n));
			repeat (k) send_sample(rand_mag(), rand_mag());
			if ($urandom_range(1) == 0) begin
				write_reg(REG_CAL_SAMPLES, CFG_W'($urandom_range(0, k)));
			end else begin
				write_reg(REG_CAL_MODE, 16'd0);
				repeat ($urandom_range(1, 6)) send_sample(rand_mag(), rand_mag());
				write_reg(REG_CAL_MODE, 16'd1);
			end
			repeat ($urandom_range(1, 20)) send_sample(rand_mag(), rand_mag());
		end
	endtask

	initial begin : result_sink
		int hold_left;
		compass_result_t got;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
				got.is_heading = is_heading;
				got.heading = heading;
				got.heading_diff = heading_diff;
				got.cal_done = cal_done;
				got.ofs_x = cal_offset_x;
				got.ofs_y = cal_offset_y;
				sb.check_result(got);
			end
			if (hold_off_req) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < out_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int base;
		bit late_hold_done;
		late_hold_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		held_burst();
		base = beats_sent;
		while (beats_sent - base < RANDOM_BEATS) begin
			if (beats_sent - base < RANDOM_BEATS / 3) begin
				in_idle_pct = 9;
				out_idle_pct = 80;
			end else if (beats_sent - base < 2 * RANDOM_BEATS / 3) begin
				in_idle_pct = 80;
				out_idle_pct = 9;
			end else begin
				in_idle_pct = 0;
				out_idle_pct = 0;
				if (!late_hold_done) begin
					late_hold_done = 1'b1;
					held_burst();
				end
			end
			run_phase();
		end
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (CORDIC_ITERATIONS + 10) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
